@@ rtl/gbd_pkg.sv @@
`default_nettype none
package gbd_pkg;

  localparam int unsigned COLS_MAX = 1024;
  localparam int unsigned ROWS_MAX = 1024;
  localparam int unsigned R_MAX    = 4;

  localparam int unsigned HSLOTS = 2 * R_MAX;
  localparam int unsigned SSLOTS = R_MAX;
  localparam int unsigned WIN    = 2 * R_MAX + 1;

  localparam int unsigned COL_W  = $clog2(COLS_MAX);
  localparam int unsigned ROW_W  = $clog2(ROWS_MAX);
  localparam int unsigned HS_W   = $clog2(HSLOTS);
  localparam int unsigned SS_W   = $clog2(SSLOTS);
  localparam int unsigned RAD_W  = $clog2(R_MAX + 1);
  localparam int unsigned TAP_W  = $clog2(WIN);
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned NREG   = 8;
  localparam int unsigned ADDR_W = $clog2(NREG) + 2;

  typedef logic signed [15:0] pix_t;

  typedef enum logic [$clog2(NREG)-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_RADIUS       = 3'd2,
    REG_COEF_0       = 3'd3,
    REG_COEF_1       = 3'd4,
    REG_COEF_2       = 3'd5,
    REG_COEF_3       = 3'd6,
    REG_COEF_4       = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SRC, S_ORIG, S_HMUL, S_HACC, S_VRD, S_VMUL, S_VACC, S_OUT
  } bstate_e;

  // Effective sizes after clamping, and the weights.
  typedef struct packed {
    logic [COL_W-1:0]        w_m1;
    logic [ROW_W-1:0]        h_m1;
    logic [RAD_W-1:0]        rr;
    logic [R_MAX:0][15:0]    coef;
  } cfg_t;

  // One request's work: a run of columns, or one drained pixel.
  typedef struct packed {
    logic                    flush;
    logic                    emit;
    logic [COL_W-1:0]        x;
    logic [COL_W-1:0]        c_lo;
    logic [COL_W-1:0]        c_hi;
    logic [ROW_W-1:0]        vrow;
    logic [ROW_W-1:0]        wrow;
    pix_t [WIN-1:0]          win;
  } task_t;

endpackage
`default_nettype wire

@@ rtl/gbd_in_if.sv @@
`default_nettype none
interface gbd_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [15:0] pixel;
  modport source (output valid, output op, output pixel, input ready);
  modport sink (input valid, input op, input pixel, output ready);
endinterface
`default_nettype wire

@@ rtl/gbd_out_if.sv @@
`default_nettype none
interface gbd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] blurred;
  logic signed [15:0] difference;
  logic [9:0]         out_col;
  logic [9:0]         out_row;
  logic               last;
  modport source (output valid, output blurred, output difference, output out_col,
                  output out_row, output last, input ready);
  modport sink (input valid, input blurred, input difference, input out_col,
                input out_row, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/gbd_front.sv @@
`default_nettype none
module gbd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gbd_pkg::cfg_t  cfg_i,
  input  logic           restart_i,
  gbd_in_if.sink         in_i,
  input  logic           full_i,
  output logic           push_o,
  output gbd_pkg::task_t task_o
);
  import gbd_pkg::*;

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W:0]     row_q, row_d;
  logic [COL_W-1:0]   dcol_q, dcol_d;
  logic [RAD_W-1:0]   drow_q, drow_d;
  pix_t [WIN-1:0]     win_q, win_d;

  logic               accept, wrap, row_end, have_cols, frame_done, flush_act;
  logic [COL_W-1:0]   x;
  logic [ROW_W-1:0]   y;
  logic [ROW_W:0]     h;
  logic [RAD_W-1:0]   rows_left;
  pix_t [WIN-1:0]     win_new;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    h          = {1'b0, cfg_i.h_m1} + 1'b1;
    frame_done = row_q > {1'b0, cfg_i.h_m1};
    wrap       = frame_done || (col_q > cfg_i.w_m1);
    x          = wrap ? '0 : col_q;
    y          = wrap ? '0 : row_q[ROW_W-1:0];
    row_end    = x == cfg_i.w_m1;
    have_cols  = row_end || (x >= COL_W'(cfg_i.rr));
    rows_left  = ((ROW_W+1)'(cfg_i.rr) < h) ? cfg_i.rr : h[RAD_W-1:0];
    flush_act  = frame_done && (drow_q < rows_left);

    win_new[0] = pix_t'(in_i.pixel);
    for (int k = 1; k < WIN; k++) begin
      win_new[k] = (x == '0) ? pix_t'(in_i.pixel) : win_q[k-1];
    end

    task_o.flush = in_i.op;
    task_o.win   = in_i.op ? win_q : win_new;
    task_o.x     = x;
    task_o.wrow  = y;
    if (in_i.op) begin
      task_o.emit = 1'b1;
      task_o.c_lo = dcol_q;
      task_o.c_hi = dcol_q;
      task_o.vrow = ROW_W'(h - (ROW_W+1)'(rows_left) + (ROW_W+1)'(drow_q));
    end else begin
      task_o.emit = y >= ROW_W'(cfg_i.rr);
      task_o.vrow = y - ROW_W'(cfg_i.rr);
      task_o.c_hi = row_end ? x : x - COL_W'(cfg_i.rr);
      task_o.c_lo = (x >= COL_W'(cfg_i.rr)) ? x - COL_W'(cfg_i.rr) : '0;
    end
    push_o = accept && (in_i.op ? flush_act : have_cols);

    col_d  = col_q;
    row_d  = row_q;
    dcol_d = dcol_q;
    drow_d = drow_q;
    win_d  = win_q;
    if (restart_i) begin
      col_d  = '0;
      row_d  = '0;
      dcol_d = '0;
      drow_d = '0;
    end else if (accept && !in_i.op) begin
      win_d = win_new;
      if (wrap) begin
        dcol_d = '0;
        drow_d = '0;
      end
      if (row_end) begin
        col_d = '0;
        row_d = {1'b0, y} + 1'b1;
      end else begin
        col_d = x + 1'b1;
        row_d = {1'b0, y};
      end
    end else if (accept && flush_act) begin
      if (dcol_q == cfg_i.w_m1) begin
        dcol_d = '0;
        drow_d = drow_q + 1'b1;
      end else begin
        dcol_d = dcol_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      dcol_q <= '0;
      drow_q <= '0;
      win_q  <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      dcol_q <= dcol_d;
      drow_q <= drow_d;
      win_q  <= win_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/gbd_fifo.sv @@
`default_nettype none
module gbd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gbd_pkg::task_t data_i,
  input  logic           pop_i,
  output gbd_pkg::task_t data_o,
  output logic           empty_o,
  output logic           full_o
);
  import gbd_pkg::*;

  task_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0]   rd_q, wr_q;
  logic [QPTR_W:0]     cnt_q;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == (QPTR_W+1)'(QDEPTH);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

@@ rtl/gbd_back.sv @@
`default_nettype none
module gbd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gbd_pkg::cfg_t  cfg_i,
  input  gbd_pkg::task_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  gbd_out_if.source      out_o
);
  import gbd_pkg::*;

  localparam int unsigned PW   = COL_W + 3;
  localparam int unsigned VW   = ROW_W + 3;
  localparam int unsigned VACW = 56;

  bstate_e                 state_q, state_d;
  logic [COL_W-1:0]        col_q, col_d;
  logic [TAP_W-1:0]        tap_q, tap_d;
  logic signed [31:0]      hacc_q, hacc_d;
  logic signed [VACW-1:0]  vacc_q, vacc_d;
  logic signed [33:0]      hprod_q;
  logic signed [48:0]      vprod_q;
  pix_t                    orig_q;
  logic                    usecur_q;
  logic [RAD_W-1:0]        vabs_q;

  logic [31:0]             hmem [HSLOTS*COLS_MAX];
  logic [15:0]             smem [SSLOTS*COLS_MAX];
  logic [31:0]             hrd_q;
  logic [15:0]             srd_q;

  logic                    out_valid_q, out_last_q;
  pix_t                    out_blur_q, out_diff_q;
  logic [COL_W-1:0]        out_col_q;
  logic [ROW_W-1:0]        out_row_q;

  logic                    mem_we, out_load, can_go;
  logic [HS_W+COL_W-1:0]   hraddr;
  logic [SS_W+COL_W-1:0]   sraddr;
  pix_t                    own, pa, pb, blur;
  logic signed [16:0]      hop, dif;
  logic signed [PW-1:0]    pcol;
  logic signed [VW-1:0]    q;
  logic [TAP_W-1:0]        tap_end;
  logic [RAD_W-1:0]        vabs;
  logic [VACW-1:0]         mag;
  logic [VACW-31:0]        sh;
  logic signed [31:0]      hval;

  function automatic pix_t wpix(input pix_t [WIN-1:0] win, input logic [COL_W-1:0] x,
                                input logic signed [PW-1:0] pos,
                                input logic [COL_W-1:0] w_m1);
    logic signed [PW-1:0] cl;
    logic signed [PW-1:0] k;
    cl = pos;
    if (pos < 0) begin
      cl = '0;
    end else if (pos > signed'(PW'(w_m1))) begin
      cl = signed'(PW'(w_m1));
    end
    k = signed'(PW'(x)) - cl;
    if (k < 0) begin
      k = '0;
    end else if (k > signed'(PW'(WIN - 1))) begin
      k = signed'(PW'(WIN - 1));
    end
    return win[k[TAP_W-1:0]];
  endfunction

  always_comb begin
    pcol    = signed'(PW'(col_q));
    own     = wpix(head_i.win, head_i.x, pcol, cfg_i.w_m1);
    pa      = wpix(head_i.win, head_i.x, pcol - signed'(PW'(tap_q)), cfg_i.w_m1);
    pb      = wpix(head_i.win, head_i.x, pcol + signed'(PW'(tap_q)), cfg_i.w_m1);
    hop     = (tap_q == '0) ? 17'(pa) : 17'(pa) + 17'(pb);
    tap_end = TAP_W'({cfg_i.rr, 1'b0});

    // Vertical tap row, clamped to the frame.
    q = signed'(VW'(head_i.vrow)) + signed'(VW'(tap_q)) - signed'(VW'(cfg_i.rr));
    if (q < 0) begin
      q = '0;
    end else if (q > signed'(VW'(cfg_i.h_m1))) begin
      q = signed'(VW'(cfg_i.h_m1));
    end
    vabs = (tap_q >= TAP_W'(cfg_i.rr)) ? RAD_W'(tap_q - TAP_W'(cfg_i.rr))
                                       : RAD_W'(TAP_W'(cfg_i.rr) - tap_q);
    hval = usecur_q ? hacc_q : signed'(hrd_q);

    hraddr = {q[HS_W-1:0], col_q};
    sraddr = {head_i.vrow[SS_W-1:0], col_q};

    // Truncation toward zero, then saturation.
    mag = vacc_q[VACW-1] ? VACW'(-vacc_q) : VACW'(vacc_q);
    sh  = mag[VACW-1:30];
    if (!vacc_q[VACW-1]) begin
      blur = (sh > (VACW-30)'(32767)) ? 16'sd32767 : pix_t'(sh[15:0]);
    end else begin
      blur = (sh > (VACW-30)'(32768)) ? -16'sd32768 : pix_t'(-sh[15:0]);
    end
    dif = 17'(blur) - 17'(orig_q);

    can_go   = !head_i.emit || !out_valid_q || out_o.ready;
    state_d  = state_q;
    col_d    = col_q;
    tap_d    = tap_q;
    hacc_d   = hacc_q;
    vacc_d   = vacc_q;
    mem_we   = 1'b0;
    out_load = 1'b0;
    pop_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          col_d   = head_i.c_lo;
          state_d = S_SRC;
        end
      end
      S_SRC:  state_d = S_ORIG;
      S_ORIG: begin
        hacc_d  = '0;
        vacc_d  = '0;
        tap_d   = '0;
        state_d = head_i.flush ? S_VRD : S_HMUL;
      end
      S_HMUL: state_d = S_HACC;
      S_HACC: begin
        hacc_d = hacc_q + signed'(hprod_q[31:0]);
        if (tap_q == TAP_W'(cfg_i.rr)) begin
          tap_d   = '0;
          state_d = S_VRD;
        end else begin
          tap_d   = tap_q + 1'b1;
          state_d = S_HMUL;
        end
      end
      S_VRD:  state_d = S_VMUL;
      S_VMUL: state_d = S_VACC;
      S_VACC: begin
        vacc_d = vacc_q + VACW'(vprod_q);
        if (tap_q == tap_end) begin
          state_d = S_OUT;
        end else begin
          tap_d   = tap_q + 1'b1;
          state_d = S_VRD;
        end
      end
      S_OUT: begin
        if (can_go) begin
          mem_we   = !head_i.flush;
          out_load = head_i.emit;
          if (col_q == head_i.c_hi) begin
            pop_o   = 1'b1;
            state_d = S_IDLE;
          end else begin
            col_d   = col_q + 1'b1;
            state_d = S_SRC;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Line stores: the current column is written only after its reads.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hmem[{head_i.wrow[HS_W-1:0], col_q}] <= hacc_q;
      smem[{head_i.wrow[SS_W-1:0], col_q}] <= own;
    end
    hrd_q <= hmem[hraddr];
    srd_q <= smem[sraddr];
  end

  always_ff @(posedge clk_i) begin
    hprod_q <= hop * signed'({1'b0, cfg_i.coef[tap_q[RAD_W-1:0]]});
    vprod_q <= hval * signed'({1'b0, cfg_i.coef[vabs_q]});
    if (state_q == S_VRD) begin
      usecur_q <= !head_i.flush && (q[ROW_W-1:0] == head_i.wrow);
      vabs_q   <= vabs;
    end
    if (state_q == S_ORIG) begin
      orig_q <= (!head_i.flush && cfg_i.rr == '0) ? own : pix_t'(srd_q);
    end
    if (out_load) begin
      out_blur_q <= blur;
      out_diff_q <= (dif > 17'sd32767) ? 16'sd32767 :
                    (dif < -17'sd32768) ? -16'sd32768 : pix_t'(dif[15:0]);
      out_col_q  <= col_q;
      out_row_q  <= head_i.vrow;
      out_last_q <= col_q == head_i.c_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      tap_q       <= '0;
      hacc_q      <= '0;
      vacc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      tap_q   <= tap_d;
      hacc_q  <= hacc_d;
      vacc_q  <= vacc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.blurred    = out_blur_q;
  assign out_o.difference = out_diff_q;
  assign out_o.out_col    = out_col_q;
  assign out_o.out_row    = out_row_q;
  assign out_o.last       = out_last_q;

`ifndef ASSERT_OFF
  a_htap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HACC |-> tap_q <= TAP_W'(cfg_i.rr))
    else $error("horizontal tap beyond radius");
  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !empty_i && col_q >= head_i.c_lo && col_q <= head_i.c_hi)
    else $error("column outside the run of the queued request");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && can_go && head_i.emit |=> out_valid_q)
    else $error("result not presented");
`endif

endmodule
`default_nettype wire

@@ rtl/gaussian_blur_and_difference_unit.sv @@
// Channel   Dir  Payload                                          Done when
// in_i      in   op, pixel                                        valid & ready
// out_o     out  blurred, difference, out_col, out_row, last      valid & ready
// APB       in   registers 0..7 at byte address 4*i               psel & penable & pwrite
//
// Each request is taken from the idle state and then handled column by column (R = radius):
// source read, horizontal multiply and accumulate over taps 0..R, then vertical read,
// multiply and accumulate over 2R+1 rows; a drained pixel skips the horizontal taps.
// A request ending a row costs up to R+1 columns; others one column or none.
// The two-entry request queue lets the input run ahead while results stall.
// Reset clears counters, window and queue; line stores are not cleared.
`default_nettype none
module gaussian_blur_and_difference_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  gbd_in_if.sink                     in_i,
  gbd_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import gbd_pkg::*;

  logic [10:0]          width_q, height_q;
  logic [2:0]           radius_q;
  logic [R_MAX:0][15:0] coef_q;
  cfg_t                 cfg;
  reg_e                 idx;
  logic                 wr_en, restart, push, pop, empty, full;
  task_t                task_in, head;

  assign pready  = 1'b1;
  assign idx     = reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign restart = wr_en && (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT ||
                             idx == REG_RADIUS);

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:  prdata = 32'(width_q);
      REG_FRAME_HEIGHT: prdata = 32'(height_q);
      REG_RADIUS:       prdata = 32'(radius_q);
      default:          prdata = 32'(coef_q[idx - REG_COEF_0]);
    endcase

    cfg.w_m1 = (width_q == '0) ? '0 :
               (width_q > 11'(COLS_MAX)) ? COL_W'(COLS_MAX - 1) : COL_W'(width_q - 1'b1);
    cfg.h_m1 = (height_q == '0) ? '0 :
               (height_q > 11'(ROWS_MAX)) ? ROW_W'(ROWS_MAX - 1) : ROW_W'(height_q - 1'b1);
    cfg.rr   = (radius_q > 3'(R_MAX)) ? RAD_W'(R_MAX) : RAD_W'(radius_q);
    cfg.coef = coef_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'(COLS_MAX);
      height_q <= 11'(ROWS_MAX);
      radius_q <= 3'd2;
      coef_q   <= {{R_MAX{16'h0000}}, 16'h8000};
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAME_WIDTH:  width_q  <= pwdata[10:0];
        REG_FRAME_HEIGHT: height_q <= pwdata[10:0];
        REG_RADIUS:       radius_q <= pwdata[2:0];
        default:          coef_q[idx - REG_COEF_0] <= pwdata[15:0];
      endcase
    end
  end

  gbd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (restart),
    .in_i      (in_i),
    .full_i    (full),
    .push_o    (push),
    .task_o    (task_in)
  );

  gbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (task_in),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  gbd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
